// File: hdl/godb_pkg.sv
`default_nettype none

package godb_pkg;

  localparam int DataW     = 16;
  localparam int CoefW     = 20;
  localparam int DelayW    = 40;
  localparam int CfgIdxW   = 3;
  localparam int StepW     = 4;
  localparam int AxisW     = 2;
  localparam int NumAxes   = 3;
  localparam int Deadband  = 10;
  localparam int FracBits  = 16;

  localparam logic [AxisW-1:0] LastAxis = AxisW'(NumAxes - 1);
  localparam logic [StepW-1:0] EmitStep = 4'd8;

  // register indexes
  localparam logic [CfgIdxW-1:0] RegOffsetX = 3'd0;
  localparam logic [CfgIdxW-1:0] RegOffsetY = 3'd1;
  localparam logic [CfgIdxW-1:0] RegOffsetZ = 3'd2;
  localparam logic [CfgIdxW-1:0] RegCoefB0  = 3'd3;
  localparam logic [CfgIdxW-1:0] RegCoefB1  = 3'd4;
  localparam logic [CfgIdxW-1:0] RegCoefB2  = 3'd5;
  localparam logic [CfgIdxW-1:0] RegCoefA1  = 3'd6;
  localparam logic [CfgIdxW-1:0] RegCoefA2  = 3'd7;

  typedef enum logic [2:0] {
    OP_X,     // condition the axis sample
    OP_ACC,   // acc = b0*x + d1
    OP_MLO,   // t = a * acc[19:0]
    OP_MHI,   // t += (a * acc[39:20]) << 20
    OP_D1,    // d1 = b1*x - rnd(t) + d2
    OP_D2,    // d2 = b2*x - rnd(t), store the axis result
    OP_EMIT   // hand the three results to the output register
  } op_e;

  typedef enum logic [2:0] {
    CF_B0,
    CF_B1,
    CF_B2,
    CF_A1,
    CF_A2
  } coef_e;

  typedef struct packed {
    op_e   op;
    coef_e coef;
    logic  br;     // jump back to step 0 unless on the last axis
  } uword_t;

  typedef struct packed {
    logic             en;
    uword_t           word;
    logic [AxisW-1:0] axis;
  } dp_ctrl_t;

  // microprogram, one control word per step
  function automatic uword_t ucode(input logic [StepW-1:0] step);
    uword_t w;
    w = '{op: OP_EMIT, coef: CF_B0, br: 1'b0};
    case (step)
      4'd0: w = '{op: OP_X,    coef: CF_B0, br: 1'b0};
      4'd1: w = '{op: OP_ACC,  coef: CF_B0, br: 1'b0};
      4'd2: w = '{op: OP_MLO,  coef: CF_A1, br: 1'b0};
      4'd3: w = '{op: OP_MHI,  coef: CF_A1, br: 1'b0};
      4'd4: w = '{op: OP_D1,   coef: CF_B1, br: 1'b0};
      4'd5: w = '{op: OP_MLO,  coef: CF_A2, br: 1'b0};
      4'd6: w = '{op: OP_MHI,  coef: CF_A2, br: 1'b0};
      4'd7: w = '{op: OP_D2,   coef: CF_B2, br: 1'b1};
      4'd8: w = '{op: OP_EMIT, coef: CF_B0, br: 1'b0};
      default: w = '{op: OP_EMIT, coef: CF_B0, br: 1'b0};
    endcase
    return w;
  endfunction

  function automatic logic signed [DelayW-1:0] sat40(input logic signed [47:0] v);
    logic signed [DelayW-1:0] r;
    if (v > 48'sh007F_FFFF_FFFF) begin
      r = {1'b0, {(DelayW-1){1'b1}}};
    end else if (v < -48'sh0080_0000_0000) begin
      r = {1'b1, {(DelayW-1){1'b0}}};
    end else begin
      r = v[DelayW-1:0];
    end
    return r;
  endfunction

  function automatic logic signed [DataW-1:0] sat16(input logic signed [24:0] v);
    logic signed [DataW-1:0] r;
    if (v > 25'sd32767) begin
      r = 16'sh7FFF;
    end else if (v < -25'sd32768) begin
      r = 16'sh8000;
    end else begin
      r = v[DataW-1:0];
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// File: hdl/gyro_offset_deadband_biquad.sv
// Channel  Direction  Handshake                  Payload
// in       sink       in_valid_i / in_stall_o    raw_x_i, raw_y_i, raw_z_i
// out      source     out_valid_o / out_stall_i  filt_x_o, filt_y_o, filt_z_o
// cfg      sink       cfg_we_i (no wait)         cfg_idx_i, cfg_data_i
//
// An item is accepted, then runs 8 microcode steps per axis on the single shared
// 20x21 multiplier, then an emit step loads the output register.
// in_stall_o stays high from the accepting transfer until the results are loaded.
// Reset clears the filter delays, the sequencer and the output valid; coefficients
// return to a pass-through filter (b0 = 1.0) and offsets to zero.
// A stalled output holds the sequencer on its emit step; the finished output register
// waits for its transfer while the next item is worked on.
`default_nettype none

module gyro_offset_deadband_biquad (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  input  wire logic                               in_valid_i,
  output logic                                    in_stall_o,
  input  wire logic signed [godb_pkg::DataW-1:0]  raw_x_i,
  input  wire logic signed [godb_pkg::DataW-1:0]  raw_y_i,
  input  wire logic signed [godb_pkg::DataW-1:0]  raw_z_i,
  output logic                                    out_valid_o,
  input  wire logic                               out_stall_i,
  output logic signed [godb_pkg::DataW-1:0]       filt_x_o,
  output logic signed [godb_pkg::DataW-1:0]       filt_y_o,
  output logic signed [godb_pkg::DataW-1:0]       filt_z_o,
  input  wire logic                               cfg_we_i,
  input  wire logic [godb_pkg::CfgIdxW-1:0]       cfg_idx_i,
  input  wire logic [godb_pkg::CoefW-1:0]         cfg_data_i
);

  logic                              busy_q;
  logic                              out_valid_q;
  logic [godb_pkg::StepW-1:0]        step_q;
  logic [godb_pkg::AxisW-1:0]        axis_q;
  logic signed [godb_pkg::DataW-1:0] raw_x_q, raw_y_q, raw_z_q;
  logic signed [godb_pkg::DataW-1:0] filt_x_q, filt_y_q, filt_z_q;
  logic signed [godb_pkg::DataW-1:0] res_x, res_y, res_z;
  godb_pkg::uword_t                  uword;
  godb_pkg::dp_ctrl_t                dp_ctrl;
  logic                              in_xfer;
  logic                              emit;

  // fetch the control word of the current step
  assign uword   = godb_pkg::ucode(step_q);
  assign in_xfer = in_valid_i && !busy_q;
  // results move to the output register once it is empty or being drained
  assign emit    = busy_q && (uword.op == godb_pkg::OP_EMIT) &&
                   (!out_valid_q || !out_stall_i);

  assign dp_ctrl = '{en: busy_q, word: uword, axis: axis_q};

  // sequencer, output valid and output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      out_valid_q <= 1'b0;
      step_q      <= '0;
      axis_q      <= '0;
      filt_x_q    <= '0;
      filt_y_q    <= '0;
      filt_z_q    <= '0;
    end else begin
      if (!busy_q) begin
        if (in_valid_i) begin
          busy_q <= 1'b1;
          step_q <= '0;
          axis_q <= '0;
        end
      end else if (uword.op == godb_pkg::OP_EMIT) begin
        if (emit) begin
          busy_q <= 1'b0;
          step_q <= '0;
          axis_q <= '0;
        end
      end else if (uword.br && axis_q != godb_pkg::LastAxis) begin
        // jump back to the top of the program for the next axis
        axis_q <= axis_q + 2'd1;
        step_q <= '0;
      end else begin
        step_q <= step_q + 4'd1;
      end

      if (emit) begin
        out_valid_q <= 1'b1;
        filt_x_q    <= res_x;
        filt_y_q    <= res_y;
        filt_z_q    <= res_z;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // capture the sample on its transfer
  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      raw_x_q <= raw_x_i;
      raw_y_q <= raw_y_i;
      raw_z_q <= raw_z_i;
    end
  end

  godb_dp u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .ctrl_i     (dp_ctrl),
    .raw_x_i    (raw_x_q),
    .raw_y_i    (raw_y_q),
    .raw_z_i    (raw_z_q),
    .res_x_o    (res_x),
    .res_y_o    (res_y),
    .res_z_o    (res_z)
  );

  assign in_stall_o  = busy_q;
  assign out_valid_o = out_valid_q;
  assign filt_x_o    = filt_x_q;
  assign filt_y_o    = filt_y_q;
  assign filt_z_o    = filt_z_q;

  // the program counter never runs past the emit step
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_q <= godb_pkg::EmitStep)
    else $error("step counter beyond program");

  // only three axes exist
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    axis_q <= godb_pkg::LastAxis)
    else $error("axis counter out of range");

  // an idle sequencer sits at the start of the program
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !busy_q |-> (step_q == '0 && axis_q == '0))
    else $error("idle sequencer not at program start");

  // a new result appears only from the emit step of the last axis
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(busy_q && step_q == godb_pkg::EmitStep &&
                                 axis_q == godb_pkg::LastAxis))
    else $error("output loaded outside the emit step");

  // the emit step is reached only after the last axis
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (busy_q && step_q == godb_pkg::EmitStep) |-> axis_q == godb_pkg::LastAxis)
    else $error("emit step reached early");

endmodule

`default_nettype wire

// File: hdl/godb_dp.sv
`default_nettype none

module godb_dp (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire logic                                cfg_we_i,
  input  wire logic [godb_pkg::CfgIdxW-1:0]        cfg_idx_i,
  input  wire logic [godb_pkg::CoefW-1:0]          cfg_data_i,
  input  wire godb_pkg::dp_ctrl_t                  ctrl_i,
  input  wire logic signed [godb_pkg::DataW-1:0]   raw_x_i,
  input  wire logic signed [godb_pkg::DataW-1:0]   raw_y_i,
  input  wire logic signed [godb_pkg::DataW-1:0]   raw_z_i,
  output logic signed [godb_pkg::DataW-1:0]        res_x_o,
  output logic signed [godb_pkg::DataW-1:0]        res_y_o,
  output logic signed [godb_pkg::DataW-1:0]        res_z_o
);

  logic signed [godb_pkg::DataW-1:0]  offset_x_q, offset_y_q, offset_z_q;
  logic signed [godb_pkg::CoefW-1:0]  b0_q, b1_q, b2_q, a1_q, a2_q;
  logic signed [godb_pkg::DelayW-1:0] d1_q [godb_pkg::NumAxes];
  logic signed [godb_pkg::DelayW-1:0] d2_q [godb_pkg::NumAxes];
  logic signed [godb_pkg::DataW-1:0]  res_q [godb_pkg::NumAxes];

  logic signed [godb_pkg::DataW-1:0]  x_q;
  logic signed [godb_pkg::DelayW-1:0] acc_q;
  logic signed [59:0]                 t_q;

  logic signed [godb_pkg::DataW-1:0]  raw_sel, off_sel, x_sat, x_d;
  logic signed [16:0]                 raw_ext, mag;
  logic signed [17:0]                 diff;
  logic signed [godb_pkg::CoefW-1:0]  mul_a;
  logic signed [20:0]                 mul_b;
  logic signed [40:0]                 mul_ax, mul_bx, prod;
  logic signed [47:0]                 prod48, fa48, d1_sel48, d2_sel48;
  logic signed [59:0]                 t_rnd;
  logic signed [40:0]                 acc_rnd;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      offset_x_q <= '0;
      offset_y_q <= '0;
      offset_z_q <= '0;
      b0_q       <= 20'sh10000;
      b1_q       <= '0;
      b2_q       <= '0;
      a1_q       <= '0;
      a2_q       <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        godb_pkg::RegOffsetX: offset_x_q <= cfg_data_i[godb_pkg::DataW-1:0];
        godb_pkg::RegOffsetY: offset_y_q <= cfg_data_i[godb_pkg::DataW-1:0];
        godb_pkg::RegOffsetZ: offset_z_q <= cfg_data_i[godb_pkg::DataW-1:0];
        godb_pkg::RegCoefB0:  b0_q       <= cfg_data_i;
        godb_pkg::RegCoefB1:  b1_q       <= cfg_data_i;
        godb_pkg::RegCoefB2:  b2_q       <= cfg_data_i;
        godb_pkg::RegCoefA1:  a1_q       <= cfg_data_i;
        godb_pkg::RegCoefA2:  a2_q       <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // axis conditioning: negate y and z, subtract offset, saturate, deadband
  always_comb begin
    case (ctrl_i.axis)
      2'd0:    begin raw_sel = raw_x_i; off_sel = offset_x_q; end
      2'd1:    begin raw_sel = raw_y_i; off_sel = offset_y_q; end
      default: begin raw_sel = raw_z_i; off_sel = offset_z_q; end
    endcase
    raw_ext = (ctrl_i.axis == 2'd0) ? 17'(raw_sel) : -17'(raw_sel);
    diff    = 18'(raw_ext) - 18'(off_sel);
    if (diff > 18'sd32767) begin
      x_sat = 16'sh7FFF;
    end else if (diff < -18'sd32768) begin
      x_sat = 16'sh8000;
    end else begin
      x_sat = diff[godb_pkg::DataW-1:0];
    end
    mag = (x_sat < 0) ? -17'(x_sat) : 17'(x_sat);
    x_d = (mag < 17'(godb_pkg::Deadband)) ? '0 : x_sat;
  end

  // shared multiplier
  always_comb begin
    case (ctrl_i.word.coef)
      godb_pkg::CF_B0: mul_a = b0_q;
      godb_pkg::CF_B1: mul_a = b1_q;
      godb_pkg::CF_B2: mul_a = b2_q;
      godb_pkg::CF_A1: mul_a = a1_q;
      godb_pkg::CF_A2: mul_a = a2_q;
      default:         mul_a = b0_q;
    endcase
    case (ctrl_i.word.op)
      godb_pkg::OP_MLO: mul_b = {1'b0, acc_q[19:0]};
      godb_pkg::OP_MHI: mul_b = {acc_q[39], acc_q[39:20]};
      default:          mul_b = 21'(x_q);
    endcase
  end

  assign mul_ax = 41'(mul_a);
  assign mul_bx = 41'(mul_b);
  assign prod   = mul_ax * mul_bx;
  assign prod48 = 48'(prod);

  assign t_rnd    = t_q + 60'sd32768;
  assign fa48     = 48'($signed(t_rnd[59:godb_pkg::FracBits]));
  assign d1_sel48 = 48'(d1_q[ctrl_i.axis]);
  assign d2_sel48 = 48'(d2_q[ctrl_i.axis]);
  assign acc_rnd  = 41'(acc_q) + 41'sd32768;

  // working registers and results
  always_ff @(posedge clk_i) begin
    if (ctrl_i.en) begin
      case (ctrl_i.word.op)
        godb_pkg::OP_X:   x_q   <= x_d;
        godb_pkg::OP_ACC: acc_q <= godb_pkg::sat40(prod48 + d1_sel48);
        godb_pkg::OP_MLO: t_q   <= 60'(prod);
        godb_pkg::OP_MHI: t_q   <= t_q + (60'(prod) <<< 20);
        godb_pkg::OP_D2:  res_q[ctrl_i.axis] <= godb_pkg::sat16(acc_rnd[40:godb_pkg::FracBits]);
        default: ;
      endcase
    end
  end

  // filter delays, cleared at reset
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < godb_pkg::NumAxes; i++) begin
        d1_q[i] <= '0;
        d2_q[i] <= '0;
      end
    end else if (ctrl_i.en) begin
      case (ctrl_i.word.op)
        godb_pkg::OP_D1: d1_q[ctrl_i.axis] <= godb_pkg::sat40(prod48 - fa48 + d2_sel48);
        godb_pkg::OP_D2: d2_q[ctrl_i.axis] <= godb_pkg::sat40(prod48 - fa48);
        default: ;
      endcase
    end
  end

  assign res_x_o = res_q[0];
  assign res_y_o = res_q[1];
  assign res_z_o = res_q[2];

endmodule

`default_nettype wire

// File: test/gyro_offset_deadband_biquad_tb.sv
module gyro_offset_deadband_biquad_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import godb_pkg::*;

  localparam int     NumRows      = 47;   // rows of the directed plan below
  localparam int     NumPhases    = 9;    // coefficient settings in the random part
  localparam int     PhaseItems   = 100;  // samples per random setting
  localparam int     SettleCycles = 40;   // settle time after the last item, with margin
  localparam longint Sat40Hi      = (longint'(1) <<< (DelayW - 1)) - 1;
  localparam longint Sat40Lo      = -(longint'(1) <<< (DelayW - 1));

  // One word per axis, entry 0 is x, 1 is y, 2 is z.
  typedef logic [NumAxes-1:0][DataW-1:0] axes_t;

  typedef enum logic {ROW_SAMPLE, ROW_WRITE} row_kind_e;

  // How the taps of a random phase are chosen.
  typedef enum logic [1:0] {MODE_PASS, MODE_LOWPASS, MODE_WILD, MODE_EDGE} tap_mode_e;

  typedef struct packed {
    row_kind_e           kind;
    logic [CfgIdxW-1:0]  idx;
    logic [CoefW-1:0]    data;
    axes_t               raw;
    logic                fixed_want;  // result typed into the row, not predicted
    axes_t               want;
  } row_t;

  logic                     clk_i       = 1'b0;
  logic                     rst_ni      = 1'b0;
  logic                     in_valid_i  = 1'b0;
  logic                     in_stall_o;
  logic signed [DataW-1:0]  raw_x_i     = '0;
  logic signed [DataW-1:0]  raw_y_i     = '0;
  logic signed [DataW-1:0]  raw_z_i     = '0;
  logic                     out_valid_o;
  logic                     out_stall_i = 1'b0;
  logic signed [DataW-1:0]  filt_x_o;
  logic signed [DataW-1:0]  filt_y_o;
  logic signed [DataW-1:0]  filt_z_o;
  logic                     cfg_we_i    = 1'b0;
  logic [CfgIdxW-1:0]       cfg_idx_i   = '0;
  logic [CoefW-1:0]         cfg_data_i  = '0;

  // Shadow of the block: offsets, shared taps (indexed by coef_e) and the per-axis delays.
  longint ofs  [NumAxes];
  longint tap  [5];
  longint dly1 [NumAxes];
  longint dly2 [NumAxes];

  axes_t  pending_rates [$];   // filtered rates still owed by the block, oldest first
  int     n_errors  = 0;
  int     n_sent    = 0;
  int     n_checked = 0;
  int     rx_hold   = 0;       // output stall cycles left for the current result
  bit     in_calm   = 1'b0;    // no input gaps in this stretch
  bit     rx_calm   = 1'b0;    // no output stalls in this stretch
  string  axis_tag  = "xyz";
  logic [(1 << CfgIdxW)-1:0] regs_seen = '0;

  gyro_offset_deadband_biquad dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .raw_x_i     (raw_x_i),
    .raw_y_i     (raw_y_i),
    .raw_z_i     (raw_z_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .filt_x_o    (filt_x_o),
    .filt_y_o    (filt_y_o),
    .filt_z_o    (filt_z_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  function automatic longint clamp(input longint v, input longint lo, input longint hi);
    return (v < lo) ? lo : ((v > hi) ? hi : v);
  endfunction

  // Drop FracBits fraction bits, rounding half up (the shift floors).
  function automatic longint round_frac(input longint v);
    return (v + (longint'(1) <<< (FracBits - 1))) >>> FracBits;
  endfunction

  // Condition one sample and advance the three biquads; returns the filtered rates.
  function automatic axes_t filtered_rates(input axes_t raw);
    axes_t  r;
    longint v;
    longint acc;
    longint fa1;
    longint fa2;
    for (int a = 0; a < NumAxes; a++) begin
      v = longint'($signed(raw[a]));
      // y and z are mounted reversed; -(-32768) stays +32768 until the clamp
      if (a != 0) v = -v;
      v = clamp(v - ofs[a], -32768, 32767);
      if (v > -Deadband && v < Deadband) v = 0;
      acc     = clamp(tap[CF_B0] * v + dly1[a], Sat40Lo, Sat40Hi);
      fa1     = round_frac(tap[CF_A1] * acc);
      fa2     = round_frac(tap[CF_A2] * acc);
      dly1[a] = clamp(tap[CF_B1] * v - fa1 + dly2[a], Sat40Lo, Sat40Hi);
      dly2[a] = clamp(tap[CF_B2] * v - fa2, Sat40Lo, Sat40Hi);
      r[a]    = DataW'(clamp(round_frac(acc), -32768, 32767));
    end
    return r;
  endfunction

  function automatic int draw_wait(input bit calm);
    return calm ? 0 : int'($urandom_range(0, 4));
  endfunction

  // Mix full-range words with values around the deadband and the rails.
  function automatic logic [DataW-1:0] random_word();
    case ($urandom_range(0, 7))
      0, 1, 2, 3: return DataW'($urandom);
      4, 5:       return DataW'(int'($urandom_range(0, 24)) - 12);
      6: begin
        case ($urandom_range(0, 4))
          0:       return 16'h8000;
          1:       return 16'h7FFF;
          2:       return 16'hFFFF;
          3:       return 16'h0001;
          default: return 16'h0000;
        endcase
      end
      default:    return DataW'(int'($urandom_range(0, 2000)) - 1000);
    endcase
  endfunction

  function automatic logic [CoefW-1:0] offset_value(input tap_mode_e mode);
    case (mode)
      MODE_LOWPASS: return CoefW'(int'($urandom_range(0, 40)) - 20);
      MODE_EDGE: begin
        case ($urandom_range(0, 2))
          0:       return CoefW'(16'h8000);
          1:       return CoefW'(16'h7FFF);
          default: return '0;
        endcase
      end
      // upper data bits are random too; only the low 16 count for an offset
      default:      return CoefW'($urandom);
    endcase
  endfunction

  // Rows of the directed plan.
  function automatic row_t smp(input int x, input int y, input int z);
    row_t r;
    r      = '0;
    r.kind = ROW_SAMPLE;
    r.raw  = {DataW'(z), DataW'(y), DataW'(x)};
    return r;
  endfunction

  function automatic row_t chk(input int x, input int y, input int z,
                               input int wx, input int wy, input int wz);
    row_t r;
    r            = smp(x, y, z);
    r.fixed_want = 1'b1;
    r.want       = {DataW'(wz), DataW'(wy), DataW'(wx)};
    return r;
  endfunction

  function automatic row_t wr(input logic [CfgIdxW-1:0] idx, input logic [CoefW-1:0] data);
    row_t r;
    r      = '0;
    r.kind = ROW_WRITE;
    r.idx  = idx;
    r.data = data;
    return r;
  endfunction

  // Write one register at the next edge and mirror it; leave the write enable high so
  // back-to-back writes do not toggle it within one step. Callers lower it afterwards.
  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CoefW-1:0] data);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    regs_seen[idx] = 1'b1;
    case (idx)
      RegOffsetX, RegOffsetY, RegOffsetZ: ofs[idx] = longint'($signed(data[DataW-1:0]));
      RegCoefB0: tap[CF_B0] = longint'($signed(data));
      RegCoefB1: tap[CF_B1] = longint'($signed(data));
      RegCoefB2: tap[CF_B2] = longint'($signed(data));
      RegCoefA1: tap[CF_A1] = longint'($signed(data));
      RegCoefA2: tap[CF_A2] = longint'($signed(data));
      default: ;
    endcase
  endtask

  // Offer one sample and return at the edge of its transfer. Valid stays high on exit so a
  // zero gap runs straight into the next sample; a nonzero gap drops it first.
  task automatic send_sample(input axes_t raw, input logic fixed_want, input axes_t want);
    int    gap;
    axes_t rates;
    gap = draw_wait(in_calm);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    raw_x_i    <= raw[0];
    raw_y_i    <= raw[1];
    raw_z_i    <= raw[2];
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    // Advance the shadow filters even when the row carries its own result.
    rates = filtered_rates(raw);
    pending_rates.push_back(fixed_want ? want : rates);
    n_sent++;
  endtask

  // Hold off until every owed result has been transferred, then let the block settle.
  task automatic drain(input int settle);
    in_valid_i <= 1'b0;
    while (pending_rates.size() != 0) @(posedge clk_i);
    repeat (settle) @(posedge clk_i);
  endtask

  // Output side: compare each transfer with the oldest owed result, then draw how many
  // valid cycles to stall the next one. The countdown only runs while valid is up, so
  // every stall really lands on a waiting result.
  always @(posedge clk_i) begin
    axes_t want;
    axes_t got;
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        got = {filt_z_o, filt_y_o, filt_x_o};
        if (pending_rates.size() == 0) begin
          $error("unexpected result transfer: x %0d y %0d z %0d",
                 filt_x_o, filt_y_o, filt_z_o);
          n_errors++;
        end else begin
          want = pending_rates.pop_front();
          for (int a = 0; a < NumAxes; a++) begin
            if (got[a] !== want[a]) begin
              $error("filt_%c: expected %0d, got %0d", axis_tag[a],
                     $signed(want[a]), $signed(got[a]));
              n_errors++;
            end
          end
          n_checked++;
        end
        rx_hold = draw_wait(rx_calm);
        out_stall_i <= (rx_hold != 0);
      end else if (out_valid_o && rx_hold != 0) begin
        rx_hold--;
        out_stall_i <= (rx_hold != 0);
      end
    end
  end

  initial begin
    row_t             plan [NumRows];
    logic [CoefW-1:0] tv [5];
    tap_mode_e        mode;
    int               lp;
    bit               writing;

    // Directed plan. Typed results hold while the filter is a plain pass-through
    // (reset taps), where the output is just the conditioned sample.
    plan = '{
      // reset state: rails, negation of the most negative word, deadband edges
      chk(0, 0, 0,                    0, 0, 0),
      chk(32767, -32768, -32768,      32767, 32767, 32767),
      chk(-32768, 32767, 1,           -32768, -32767, 0),
      chk(9, -9, 10,                  0, 0, -10),
      chk(-9, 9, -10,                 0, 0, 10),
      chk(10, -10, 9,                 10, 10, 0),
      chk(-10, 11, -11,               -10, -11, 11),
      chk(21845, -21846, 15420,       21845, 21846, -15420),
      // offsets at the rails: the subtraction saturates both ways
      wr(RegOffsetX, 20'd32767),
      wr(RegOffsetY, 20'h08000),
      wr(RegOffsetZ, 20'd100),
      chk(-32768, 32767, -32768,      -32768, 0, 32668),
      chk(32767, -32768, 5,           0, 32767, -105),
      wr(RegOffsetX, 20'hF8000),      // upper bits set, low half is -32768
      wr(RegOffsetY, 20'd32767),
      wr(RegOffsetZ, 20'd0),
      chk(32767, 32767, 0,            32767, -32768, 0),
      chk(-32768, -32768, 32767,      0, 0, -32767),
      // largest taps with the most negative feedback: accumulator and delays run away
      wr(RegOffsetX, 20'd0),
      wr(RegOffsetY, 20'd0),
      wr(RegCoefB0, 20'h7FFFF),
      wr(RegCoefB1, 20'h7FFFF),
      wr(RegCoefB2, 20'h7FFFF),
      wr(RegCoefA1, 20'h80000),
      wr(RegCoefA2, 20'h80000),
      smp(32767, -32768, -32768),
      smp(32767, 32767, 32767),
      smp(-32768, 100, -9),
      smp(0, 0, 0),
      smp(1000, -1000, 12),
      // mirror image: most negative taps, largest feedback
      wr(RegCoefB0, 20'h80000),
      wr(RegCoefB1, 20'h80000),
      wr(RegCoefB2, 20'h80000),
      wr(RegCoefA1, 20'h7FFFF),
      wr(RegCoefA2, 20'h7FFFF),
      smp(-32768, 32767, 32767),
      smp(12345, -23456, -11),
      smp(0, 0, 0),
      smp(-1, 1, -1),
      // an ordinary low-pass, starting from saturated delays
      wr(RegCoefB0, 20'd1024),
      wr(RegCoefB1, 20'd2048),
      wr(RegCoefB2, 20'd1024),
      wr(RegCoefA1, 20'hE6666),
      wr(RegCoefA2, 20'h0A3D7),
      smp(1000, 1000, 1000),
      smp(1000, 1000, 1000),
      smp(-20000, 20000, 0)
    };

    // Shadow starts at the reset state: pass-through taps, zero offsets and delays.
    foreach (ofs[a]) begin
      ofs[a]  = 0;
      dly1[a] = 0;
      dly2[a] = 0;
    end
    foreach (tap[c]) tap[c] = 0;
    tap[CF_B0] = longint'(1) <<< FracBits;
    writing    = 1'b0;

    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    // Walk the directed plan; register writes only go in once the block is idle.
    foreach (plan[i]) begin
      if (plan[i].kind == ROW_WRITE) begin
        if (!writing) drain(4);
        write_reg(plan[i].idx, plan[i].data);
        writing = 1'b1;
      end else begin
        if (writing) cfg_we_i <= 1'b0;
        writing = 1'b0;
        send_sample(plan[i].raw, plan[i].fixed_want, plan[i].want);
      end
    end

    // Random part: each phase reprograms every register, then streams samples.
    // Filter state carries over from phase to phase, as it does in the block.
    for (int ph = 0; ph < NumPhases; ph++) begin
      mode = tap_mode_e'(ph % 4);
      drain(4);
      in_calm = ($urandom_range(0, 3) == 0);
      rx_calm = ($urandom_range(0, 3) == 0);
      case (mode)
        MODE_PASS: begin
          // gain only, anywhere from zero to two
          foreach (tv[c]) tv[c] = '0;
          tv[CF_B0] = CoefW'($urandom_range(0, 2 << FracBits));
        end
        MODE_LOWPASS: begin
          // stable second-order low-pass: poles inside the unit circle
          lp        = $urandom_range(1, 8192);
          tv[CF_B0] = CoefW'(lp);
          tv[CF_B1] = CoefW'(2 * lp);
          tv[CF_B2] = CoefW'(lp);
          lp        = $urandom_range(26214, 58982);
          tv[CF_A2] = CoefW'(lp);
          tv[CF_A1] = CoefW'(-int'($urandom_range(0, (1 << FracBits) + lp - 1)));
        end
        MODE_WILD: begin
          foreach (tv[c]) tv[c] = CoefW'($signed(CoefW'($urandom)) >>> $urandom_range(0, 14));
        end
        default: begin
          foreach (tv[c]) begin
            case ($urandom_range(0, 3))
              0:       tv[c] = 20'h80000;
              1:       tv[c] = 20'h7FFFF;
              2:       tv[c] = CoefW'(1 << FracBits);
              default: tv[c] = '0;
            endcase
          end
        end
      endcase
      write_reg(RegOffsetX, offset_value(mode));
      write_reg(RegOffsetY, offset_value(mode));
      write_reg(RegOffsetZ, offset_value(mode));
      write_reg(RegCoefB0, tv[CF_B0]);
      write_reg(RegCoefB1, tv[CF_B1]);
      write_reg(RegCoefB2, tv[CF_B2]);
      write_reg(RegCoefA1, tv[CF_A1]);
      write_reg(RegCoefA2, tv[CF_A2]);
      cfg_we_i <= 1'b0;
      for (int k = 0; k < PhaseItems; k++) begin
        send_sample({random_word(), random_word(), random_word()}, 1'b0, '0);
      end
    end

    // Let the last results out, then watch for strays a little longer.
    drain(SettleCycles);

    $display("Sent %0d gyro samples (%0d directed rows, %0d random phases); %0d compared.",
             n_sent, NumRows, NumPhases, n_checked);
    $display("Registers touched %b; input gaps and output stalls of 0 to 4 cycles.",
             regs_seen);
    if (n_errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  // Watchdog: a correct run needs well under a tenth of this.
  initial begin
    #2_000_000;
    $display("simulation failed");
    $finish;
  end

endmodule
